>>> src/ctc_pkg.sv
// Shared types and constants of the greedy CTC decoder.
package ctc_pkg;

  localparam int MAX_CLASSES = 8192;
  localparam int MAX_STEPS   = 256;
  localparam int SCORE_W     = 16;
  localparam int CFG_W       = 14;
  localparam int CLS_W       = 13;
  localparam int CNT_W       = 9;
  localparam int SUM_W       = 25;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int DIV_STEP_W  = $clog2(SUM_W);

  localparam logic [CFG_W-1:0] NUM_CLASSES_RST = CFG_W'(6625);
  localparam logic [CFG_W-1:0] NUM_LABELS_RST  = CFG_W'(6625);
  localparam logic [CFG_W-1:0] NO_WINNER       = '1;

  localparam logic CFG_IDX_NUM_CLASSES = 1'b0;
  localparam logic CFG_IDX_NUM_LABELS  = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // One queue entry: an optional character or error result, then an
  // optional end-of-sequence request that still needs the mean worked out.
  typedef struct packed {
    logic                      has_first;
    kind_t                     first_kind;
    logic [CLS_W-1:0]          idx;
    logic [CNT_W-1:0]          first_cnt;
    logic                      has_done;
    logic signed [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]          done_cnt;
  } ctc_entry_t;

endpackage

>>> src/ctc_if.sv
// Valid/ready channel interfaces for score input and decoder results.
interface ctc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ctc_pkg::SCORE_W-1:0]   class_score;
  logic                                 seq_end;

  modport source (output valid, class_score, seq_end, input ready);
  modport sink   (input valid, class_score, seq_end, output ready);
endinterface

interface ctc_out_if;
  logic                                 valid;
  logic                                 ready;
  ctc_pkg::kind_t                       kind;
  logic [ctc_pkg::CLS_W-1:0]            class_index;
  logic signed [ctc_pkg::SCORE_W-1:0]   avg_score;
  logic [ctc_pkg::CNT_W-1:0]            char_count;
  logic                                 last;

  modport source (output valid, kind, class_index, avg_score, char_count, last, input ready);
  modport sink   (input valid, kind, class_index, avg_score, char_count, last, output ready);
endinterface

>>> src/ctc_greedy_decoder.sv
// Top level of the greedy CTC decoder: configuration registers, the two halves and the queue between them.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  in_if   | in  | valid / ready      | class_score (s16 Q1.15), seq_end
//  out_if  | out | valid / ready      | kind, class_index, avg_score, char_count, last
//  cfg_*   | in  | cfg_we, no wait    | cfg_index (0 step size, 1 label count), cfg_wdata
//
//  Scores are taken one per cycle while the four-entry result queue has room.
//  A character or error result passes the result queue and the back-end state register
//  before it is offered on out_if; a sequence-done result also passes the serial divider.
//  Reset is synchronous; no clearing pass is needed afterward.
//  A stall on out_if backs up into the queue and then drops in_if.ready.
module ctc_greedy_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  ctc_in_if.sink                      in_if,
  ctc_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ctc_pkg::CFG_W-1:0]   cfg_wdata
);
  import ctc_pkg::*;

  logic [CFG_W-1:0] step_size_r;
  logic [CFG_W-1:0] num_labels_r;
  logic             push;
  ctc_entry_t       push_entry;
  logic             pop;
  ctc_entry_t       pop_entry;
  logic             q_full;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= NUM_CLASSES_RST;
      num_labels_r <= NUM_LABELS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_NUM_CLASSES) begin
        step_size_r <= cfg_wdata;
      end else if (cfg_index == CFG_IDX_NUM_LABELS) begin
        num_labels_r <= cfg_wdata;
      end
    end
  end

  ctc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .step_size   (step_size_r),
    .num_labels  (num_labels_r),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  ctc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  ctc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_entry (pop_entry),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

>>> src/ctc_front.sv
// Front end: per-step argmax, collapse of repeats and blanks, error check, sums.
module ctc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  ctc_in_if.sink                      in_if,
  input  logic [ctc_pkg::CFG_W-1:0]   step_size,
  input  logic [ctc_pkg::CFG_W-1:0]   num_labels,
  input  logic                        q_full,
  output logic                        push,
  output ctc_pkg::ctc_entry_t         push_entry
);
  import ctc_pkg::*;

  logic [CLS_W-1:0]          class_pos_r, class_pos_nxt;
  logic [CLS_W-1:0]          best_index_r, best_index_nxt;
  logic signed [SCORE_W-1:0] best_value_r, best_value_nxt;
  logic [CFG_W-1:0]          prev_winner_r, prev_winner_nxt;
  logic signed [SUM_W-1:0]   score_sum_r, score_sum_nxt;
  logic [CNT_W-1:0]          emit_count_r, emit_count_nxt;
  logic                      error_seen_r, error_seen_nxt;

  logic                      accept;
  logic [CFG_W-1:0]          eff;
  logic [CFG_W-1:0]          pos_inc;
  logic                      take;
  logic [CLS_W-1:0]          cand_idx;
  logic signed [SCORE_W-1:0] cand_val;
  logic                      step_end;
  logic                      new_char;
  logic                      is_err;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    if (step_size == '0) begin
      eff = CFG_W'(1);
    end else if (step_size > CFG_W'(MAX_CLASSES)) begin
      eff = CFG_W'(MAX_CLASSES);
    end else begin
      eff = step_size;
    end
  end

  assign pos_inc  = CFG_W'(class_pos_r) + CFG_W'(1);
  assign take     = (class_pos_r == '0) || (in_if.class_score > best_value_r);
  assign cand_idx = take ? class_pos_r : best_index_r;
  assign cand_val = take ? in_if.class_score : best_value_r;
  assign step_end = (pos_inc >= eff) || in_if.seq_end;
  assign new_char = (cand_idx != '0) && (CFG_W'(cand_idx) != prev_winner_r);
  assign is_err   = new_char && (CFG_W'(cand_idx) >= num_labels);

  always_comb begin
    class_pos_nxt   = class_pos_r;
    best_index_nxt  = best_index_r;
    best_value_nxt  = best_value_r;
    prev_winner_nxt = prev_winner_r;
    score_sum_nxt   = score_sum_r;
    emit_count_nxt  = emit_count_r;
    error_seen_nxt  = error_seen_r;
    push            = 1'b0;
    push_entry      = '0;

    if (accept) begin
      if (error_seen_r) begin
        // drop scores until the sequence closes
        if (in_if.seq_end) begin
          error_seen_nxt = 1'b0;
        end
      end else begin
        best_index_nxt = cand_idx;
        best_value_nxt = cand_val;
        if (step_end && is_err) begin
          push                  = 1'b1;
          push_entry.has_first  = 1'b1;
          push_entry.first_kind = KIND_ERROR;
          push_entry.idx        = cand_idx;
          push_entry.first_cnt  = emit_count_r;
          if (!in_if.seq_end) begin
            error_seen_nxt = 1'b1;
          end
        end else if (step_end) begin
          if (new_char) begin
            if (emit_count_r < CNT_W'(MAX_STEPS)) begin
              score_sum_nxt  = score_sum_r + SUM_W'(cand_val);
              emit_count_nxt = emit_count_r + CNT_W'(1);
            end
            push                  = 1'b1;
            push_entry.has_first  = 1'b1;
            push_entry.first_kind = KIND_CHAR;
            push_entry.idx        = cand_idx;
            push_entry.first_cnt  = emit_count_nxt;
          end
          prev_winner_nxt = CFG_W'(cand_idx);
          class_pos_nxt   = '0;
        end else begin
          class_pos_nxt = pos_inc[CLS_W-1:0];
        end

        if (in_if.seq_end && !is_err) begin
          push                = 1'b1;
          push_entry.has_done = 1'b1;
          push_entry.sum      = score_sum_nxt;
          push_entry.done_cnt = emit_count_nxt;
        end
      end

      // start a fresh sequence after the closing score
      if (in_if.seq_end) begin
        class_pos_nxt   = '0;
        best_index_nxt  = '0;
        best_value_nxt  = '0;
        prev_winner_nxt = NO_WINNER;
        score_sum_nxt   = '0;
        emit_count_nxt  = '0;
        error_seen_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_pos_r   <= '0;
      best_index_r  <= '0;
      best_value_r  <= '0;
      prev_winner_r <= NO_WINNER;
      score_sum_r   <= '0;
      emit_count_r  <= '0;
      error_seen_r  <= 1'b0;
    end else begin
      class_pos_r   <= class_pos_nxt;
      best_index_r  <= best_index_nxt;
      best_value_r  <= best_value_nxt;
      prev_winner_r <= prev_winner_nxt;
      score_sum_r   <= score_sum_nxt;
      emit_count_r  <= emit_count_nxt;
      error_seen_r  <= error_seen_nxt;
    end
  end

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    error_seen_r |-> !push)
    else $error("result queued while dropping an errored sequence");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    emit_count_r <= CNT_W'(MAX_STEPS))
    else $error("character count passed its cap");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("result queued without a score transfer");

endmodule

>>> src/ctc_fifo.sv
// Short queue of result entries between the front and back ends.
module ctc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ctc_pkg::ctc_entry_t  push_entry,
  input  logic                 pop,
  output ctc_pkg::ctc_entry_t  pop_entry,
  output logic                 full,
  output logic                 empty
);
  import ctc_pkg::*;

  ctc_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("entry pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("entry popped from an empty queue");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + Q_CNT_W'(1))
    else $error("queue fill level did not advance on push");

endmodule

>>> src/ctc_back.sv
// Back end: presents results and works out the mean score with a serial divider.
module ctc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ctc_pkg::ctc_entry_t  q_entry,
  output logic                 pop,
  ctc_out_if.source            out_if
);
  import ctc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIRST = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } back_state_t;

  back_state_t               state_r, state_nxt;
  ctc_entry_t                ent_r, ent_nxt;
  logic [SUM_W-1:0]          quo_r, quo_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic [DIV_STEP_W-1:0]     step_r, step_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [SCORE_W-1:0] avg_r, avg_nxt;

  logic                      fire;
  logic                      finishing;
  logic                      div_start;
  logic signed [SUM_W-1:0]   start_sum;
  logic [CNT_W:0]            trial;
  logic                      q_bit;
  logic [SCORE_W-1:0]        q_mag;

  assign fire      = out_if.valid && out_if.ready;
  assign finishing = (state_r == ST_IDLE)
                  || ((state_r == ST_FIRST) && fire && !ent_r.has_done)
                  || ((state_r == ST_DONE) && fire);
  assign pop       = finishing && !q_empty;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign q_bit = (trial >= {1'b0, ent_r.done_cnt});
  assign q_mag = {quo_r[SCORE_W-2:0], q_bit};

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    avg_nxt   = avg_r;
    div_start = 1'b0;
    start_sum = ent_r.sum;

    unique case (state_r)
      ST_IDLE, ST_DONE: begin
        if (finishing) begin
          if (!q_empty) begin
            ent_nxt = q_entry;
            if (q_entry.has_first) begin
              state_nxt = ST_FIRST;
            end else begin
              div_start = 1'b1;
              start_sum = q_entry.sum;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIRST: begin
        if (fire) begin
          if (ent_r.has_done) begin
            div_start = 1'b1;
          end else if (!q_empty) begin
            ent_nxt = q_entry;
            if (q_entry.has_first) begin
              state_nxt = ST_FIRST;
            end else begin
              div_start = 1'b1;
              start_sum = q_entry.sum;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[SUM_W-2:0], q_bit};
        rem_nxt  = q_bit ? CNT_W'(trial - {1'b0, ent_r.done_cnt}) : trial[CNT_W-1:0];
        step_nxt = step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_DONE;
          if (ent_r.done_cnt == '0) begin
            avg_nxt = '0;
          end else if (neg_r) begin
            avg_nxt = -$signed(q_mag);
          end else begin
            avg_nxt = $signed(q_mag);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (div_start) begin
      state_nxt = ST_DIV;
      neg_nxt   = start_sum[SUM_W-1];
      quo_nxt   = start_sum[SUM_W-1] ? (~start_sum + SUM_W'(1)) : start_sum;
      rem_nxt   = '0;
      step_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    avg_r  <= avg_nxt;
  end

  assign out_if.valid       = (state_r == ST_FIRST) || (state_r == ST_DONE);
  assign out_if.kind        = (state_r == ST_FIRST) ? ent_r.first_kind : KIND_DONE;
  assign out_if.class_index = (state_r == ST_FIRST) ? ent_r.idx : '0;
  assign out_if.avg_score   = (state_r == ST_DONE) ? avg_r : '0;
  assign out_if.char_count  = (state_r == ST_FIRST) ? ent_r.first_cnt : ent_r.done_cnt;
  assign out_if.last        = (state_r == ST_FIRST) ? (ent_r.first_kind == KIND_ERROR)
                                                    : 1'b1;

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> (state_r == ST_DIV || state_r == ST_DONE))
    else $error("divider left before its result was ready");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r != DIV_STEP_W'(SUM_W - 1)) |=> state_r == ST_DIV)
    else $error("divider stopped early");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> !pop)
    else $error("queue popped while dividing");

endmodule
